/* rtl/boc_pkg.sv */
// Package: widths, codes, payload types and the baseline helper of the occupancy counter.
`default_nettype none

package boc_pkg;

  localparam int unsigned AVG_DEPTH = 10;
  localparam int unsigned RANGE_W   = 13;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned MARGIN_W  = 10;
  localparam int unsigned WIN_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SLOT_W    = $clog2(AVG_DEPTH);
  localparam int unsigned ADDR_W    = SLOT_W + 1;
  localparam int unsigned SUM_W     = $clog2(AVG_DEPTH * ((2 ** RANGE_W) - 1) + 1);

  // floor(sum / AVG_DEPTH) by a rounded-up reciprocal, exact over the sum range
  localparam int unsigned AVG_SHIFT = 24;
  localparam int unsigned RECIP     = ((2 ** AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int unsigned RECIP_W   = AVG_SHIFT + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  localparam logic [STATUS_W-1:0] STATUS_PHASE_FAIL = STATUS_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(2);

  localparam logic [MARGIN_W-1:0] SPIKE_RST  = MARGIN_W'(10);
  localparam logic [MARGIN_W-1:0] OBJECT_RST = MARGIN_W'(10);
  localparam logic [WIN_W-1:0]    WINDOW_RST = WIN_W'(10);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_RIGHT,
    PH_WAIT_LEFT
  } boc_phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_ENTERED,
    EV_EXITED,
    EV_EXPIRED
  } boc_event_e;

  typedef struct packed {
    logic                side;
    logic [RANGE_W-1:0]  range_mm;
    logic [STATUS_W-1:0] range_status;
    logic                calibrate;
  } boc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] person_count;
    logic [1:0]         event_res;
    logic               detected;
    logic [RANGE_W-1:0] distance_used;
    logic [RANGE_W-1:0] baseline;
  } boc_out_t;

  typedef struct packed {
    logic               push;
    boc_event_e         evt;
    logic [COUNT_W-1:0] count;
  } boc_track_t;

  function automatic logic [RANGE_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    return prod[AVG_SHIFT +: RANGE_W];
  endfunction

endpackage

`default_nettype wire

/* rtl/boc_ring_mem.sv */
// Moving-average ring store for both sides, with per-entry valid bits.
`default_nettype none

module boc_ring_mem
  import boc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [ADDR_W-1:0]  rd_addr_i,
  output logic      [RANGE_W-1:0] rd_data_o,
  input  wire logic               wr_en_i,
  input  wire logic [ADDR_W-1:0]  wr_addr_i,
  input  wire logic [RANGE_W-1:0] wr_data_i
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [RANGE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [RANGE_W-1:0] rdata_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as the reset value, zero
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* rtl/boc_track.sv */
// Doorway crossing tracker: window phase, window countdown and occupancy count.
`default_nettype none

module boc_track
  import boc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             commit_i,
  input  wire logic             side_i,
  input  wire logic             calib_i,
  input  wire logic             hit_i,
  input  wire logic [WIN_W-1:0] win_len_i,
  output boc_track_t            track_o
);

  boc_phase_e         phase_q, phase_d, cur;
  logic [WIN_W-1:0]   window_q, window_d, win_dec;
  logic [COUNT_W-1:0] occ_q, occ_d;
  logic               other_side;

  assign cur = (phase_q == PH_WAIT_RIGHT || phase_q == PH_WAIT_LEFT) ? phase_q : PH_IDLE;
  assign other_side = (cur == PH_WAIT_RIGHT && side_i) || (cur == PH_WAIT_LEFT && !side_i);
  assign win_dec = (window_q != '0) ? window_q - 1'b1 : '0;

  always_comb begin
    phase_d  = cur;
    window_d = window_q;
    if (!calib_i) begin
      unique case (cur)
        PH_IDLE: begin
          if (hit_i) begin
            phase_d  = side_i ? PH_WAIT_LEFT : PH_WAIT_RIGHT;
            window_d = (win_len_i == '0) ? WIN_W'(1) : win_len_i;
          end
        end
        default: begin
          if (other_side) begin
            if (hit_i) begin
              phase_d  = PH_IDLE;
              window_d = '0;
            end else begin
              window_d = win_dec;
              if (win_dec == '0) begin
                phase_d = PH_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    track_o.push = calib_i || (cur == PH_IDLE && !hit_i);
    track_o.evt  = EV_NONE;
    occ_d        = occ_q;
    if (!calib_i && other_side) begin
      if (hit_i) begin
        if (cur == PH_WAIT_RIGHT) begin
          track_o.evt = EV_EXITED;
          if (occ_q != '0) begin
            occ_d = occ_q - 1'b1;
          end
        end else begin
          track_o.evt = EV_ENTERED;
          if (occ_q != '1) begin
            occ_d = occ_q + 1'b1;
          end
        end
      end else if (win_dec == '0) begin
        track_o.evt = EV_EXPIRED;
      end
    end
    track_o.count = occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      window_q <= '0;
      occ_q    <= '0;
    end else if (commit_i) begin
      phase_q  <= phase_d;
      window_q <= window_d;
      occ_q    <= occ_d;
    end
  end

  a_event_needs_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && track_o.evt != EV_NONE |-> phase_q != PH_IDLE)
    else $error("crossing event without an open window");

  a_push_no_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && track_o.push |-> track_o.evt == EV_NONE)
    else $error("average update together with a crossing event");

  a_count_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q != $past(occ_q) |-> $past(commit_i) && $past(track_o.evt == EV_ENTERED ||
                                                       track_o.evt == EV_EXITED))
    else $error("occupancy moved without a crossing");

endmodule

`default_nettype wire

/* rtl/bidirectional_occupancy_counter_unit.sv */
// Top level of the bidirectional occupancy counter: config, pipeline and sums.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i/in_ready_o    in_data_i  (boc_in_t)
//   out      output     out_valid_o/out_ready_i  out_data_o (boc_out_t)
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item at a time: the ring entry is read on the accept beat and written
// back with the new sum and slot on the commit beat, if the tracker pushes.
// A result passes the item, post and output registers; the baseline divide is
// a reciprocal multiply on the registered post sum, ahead of the output register.
// Reset leaves all ring entries reading as zero through valid bits; no sweep.
// A stalled output holds one result, one more in the stage behind it and a
// third in the read stage, which keeps in_ready_o low.
`default_nettype none

module bidirectional_occupancy_counter_unit
  import boc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire boc_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output boc_out_t                  out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MARGIN_W-1:0]  cfg_data_i
);

  logic [MARGIN_W-1:0] spike_q, object_q;
  logic [WIN_W-1:0]    window_q;

  logic [SUM_W-1:0]  sum_l_q, sum_r_q, sum_a, sum_cur, sum_new, post_sum_q;
  logic [SLOT_W-1:0] slot_l_q, slot_r_q, slot_a, slot_cur, slot_next;

  logic               a_q, p_q, out_valid_q;
  boc_in_t            item_q;
  logic [RANGE_W-1:0] base_q;
  boc_out_t           post_q, out_q, post_res;

  logic               accept, b_fire, out_load;
  logic [RANGE_W-1:0] old_val, used;
  logic [RANGE_W:0]   spike_lim;
  logic               hit;
  boc_track_t         track;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_q  <= SPIKE_RST;
      object_q <= OBJECT_RST;
      window_q <= WINDOW_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPIKE:  spike_q  <= cfg_data_i;
        CFG_OBJECT: object_q <= cfg_data_i;
        CFG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load   = p_q && (!out_valid_q || out_ready_i);
  assign b_fire     = a_q && (!p_q || out_load);
  assign in_ready_o = !a_q;
  assign accept     = in_valid_i && in_ready_o;

  assign sum_a    = in_data_i.side ? sum_r_q : sum_l_q;
  assign slot_a   = in_data_i.side ? slot_r_q : slot_l_q;
  assign sum_cur  = item_q.side ? sum_r_q : sum_l_q;
  assign slot_cur = item_q.side ? slot_r_q : slot_l_q;

  boc_ring_mem u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i ({in_data_i.side, slot_a}),
    .rd_data_o (old_val),
    .wr_en_i   (b_fire && track.push),
    .wr_addr_i ({item_q.side, slot_cur}),
    .wr_data_i (used)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      base_q <= avg_of(sum_a);
    end
  end

  // reading clean-up and detection
  assign spike_lim = {1'b0, base_q} + (RANGE_W + 1)'(spike_q);

  always_comb begin
    used = item_q.range_mm;
    if (item_q.range_status == STATUS_PHASE_FAIL) begin
      used = base_q;
    end else if (!item_q.calibrate && {1'b0, item_q.range_mm} >= spike_lim) begin
      used = base_q;
    end
  end

  assign hit = !item_q.calibrate && (RANGE_W'(object_q) <= base_q) &&
               (used <= base_q - RANGE_W'(object_q));

  assign sum_new   = sum_cur - SUM_W'(old_val) + SUM_W'(used);
  assign slot_next = (slot_cur == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_cur + 1'b1;

  boc_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (b_fire),
    .side_i    (item_q.side),
    .calib_i   (item_q.calibrate),
    .hit_i     (hit),
    .win_len_i (window_q),
    .track_o   (track)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= 1'b0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      slot_l_q    <= '0;
      slot_r_q    <= '0;
    end else begin
      if (accept) begin
        a_q <= 1'b1;
      end else if (b_fire) begin
        a_q <= 1'b0;
      end
      if (b_fire) begin
        p_q <= 1'b1;
      end else if (out_load) begin
        p_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (b_fire && track.push) begin
        if (item_q.side) begin
          sum_r_q  <= sum_new;
          slot_r_q <= slot_next;
        end else begin
          sum_l_q  <= sum_new;
          slot_l_q <= slot_next;
        end
      end
    end
  end

  always_comb begin
    post_res          = post_q;
    post_res.baseline = avg_of(post_sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      post_q.person_count  <= track.count;
      post_q.event_res     <= track.evt;
      post_q.detected      <= hit;
      post_q.distance_used <= used;
      post_q.baseline      <= '0;
      post_sum_q           <= track.push ? sum_new : sum_cur;
    end
    if (out_load) begin
      out_q <= post_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_ring_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !b_fire)
    else $error("ring read and write-back in the same cycle");

  a_commit_fills_post : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> p_q)
    else $error("committed beat lost before the output stage");

  a_post_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_q && !out_load |=> p_q && $stable(post_sum_q))
    else $error("stalled result changed in the output stage");

endmodule

`default_nettype wire
